>>> src/vhs_pkg.sv
package vhs_pkg;

	localparam int unsigned PROB_W  = 16;
	localparam int unsigned N_W     = 13;
	localparam int unsigned TMS_W   = 32;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned LIM_W   = 20;
	localparam int unsigned PAD_W   = 16;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 88;

	localparam int unsigned MAX_FRAME_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam logic [PROB_W-1:0] RST_START_THR  = 16'd22938;
	localparam logic [PROB_W-1:0] RST_HYST_OFF   = 16'd9830;
	localparam logic [LIM_W-1:0]  RST_MIN_SIL    = 20'd4000;
	localparam logic [PAD_W-1:0]  RST_PAD        = 16'd1024;
	localparam logic [LIM_W-1:0]  RST_MIN_SPEECH = 20'd1600;
	localparam logic [LIM_W-1:0]  RST_MAX_SPEECH = 20'd240000;

	typedef enum logic [IDX_W-1:0] {
		REG_START_THR  = 3'd0,
		REG_HYST_OFF   = 3'd1,
		REG_MIN_SIL    = 3'd2,
		REG_PAD        = 3'd3,
		REG_MIN_SPEECH = 3'd4,
		REG_MAX_SPEECH = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SPEECH  = 2'd1,
		MODE_SILENCE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		END_NONE    = 2'd0,
		END_FINAL   = 2'd1,
		END_DROPPED = 2'd2
	} end_kind_t;

	typedef struct packed {
		logic [PROB_W-1:0] start_thr;
		logic [PROB_W-1:0] hyst_off;
		logic [LIM_W-1:0]  min_sil;
		logic [PAD_W-1:0]  pad;
		logic [LIM_W-1:0]  min_speech;
		logic [LIM_W-1:0]  max_speech;
	} cfg_t;

	// Classified frame handed from front to back end.
	typedef struct packed {
		logic             zero;
		logic             ge_start;
		logic             lt_sil;
		logic [N_W-1:0]   n;
		logic [TMS_W-1:0] tms;
		logic             asst;
	} frame_cmd_t;

	typedef struct packed {
		logic             speech_started;
		logic             barge_in;
		logic             partial_emitted;
		logic [CNT_W-1:0] partial_length;
		end_kind_t        end_kind;
		logic [CNT_W-1:0] final_length;
		logic [TMS_W-1:0] segment_start_ms;
		mode_t            mode;
	} result_t;

endpackage

>>> src/vhs_front.sv
module vhs_front import vhs_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic              [PROB_W-1:0] speech_prob,
	input  logic              [N_W-1:0]    frame_samples,
	input  logic              [TMS_W-1:0]  frame_time_ms,
	input  logic                           assistant_speaking,
	input  cfg_t                           cfg,
	output frame_cmd_t                     cmd
);

	logic signed [PROB_W+1:0] sil_thr;
	logic signed [PROB_W+1:0] prob_s;
	logic                     oversize;

	// Silence threshold is a signed difference and may go negative.
	assign sil_thr  = $signed({2'b00, cfg.start_thr}) - $signed({2'b00, cfg.hyst_off});
	assign prob_s   = $signed({2'b00, speech_prob});
	assign oversize = {4'b0000, frame_samples} > 17'(MAX_FRAME);

	always_comb begin
		cmd.zero     = (frame_samples == '0);
		cmd.ge_start = (speech_prob >= cfg.start_thr);
		cmd.lt_sil   = (prob_s < sil_thr);
		cmd.n        = oversize ? N_W'(MAX_FRAME) : frame_samples;
		cmd.tms      = frame_time_ms;
		cmd.asst     = assistant_speaking;
	end

endmodule

>>> src/vhs_fifo.sv
module vhs_fifo import vhs_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_cmd_t push_data,
	output logic       full,
	input  logic       pop,
	output frame_cmd_t pop_data,
	output logic       not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

	frame_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W_Q-1:0]   count_q;

	assign full      = (count_q == CNT_W_Q'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/vhs_back.sv
module vhs_back import vhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	input  frame_cmd_t cmd,
	output logic       cmd_pop,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	mode_t            mode_q, mode_d;
	logic [CNT_W-1:0] speech_q, speech_d;
	logic [CNT_W-1:0] silence_q, silence_d;
	logic [PAD_W-1:0] preroll_q, preroll_d;
	logic [TMS_W-1:0] start_q, start_d;
	logic             out_valid_q;
	result_t          out_q, res_d;

	logic [PAD_W:0]   fill_sum;
	logic [PAD_W-1:0] fill;
	logic [CNT_W-1:0] act_sum, after_part, sil_sum, start_cnt;
	logic             part, sil_done, keep_final;

	assign cmd_pop   = cmd_valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Arithmetic shared by the branches below.
	always_comb begin
		fill_sum   = {1'b0, preroll_q} + (PAD_W + 1)'(cmd.n);
		fill       = (fill_sum > {1'b0, cfg.pad}) ? cfg.pad : fill_sum[PAD_W-1:0];
		start_cnt  = CNT_W'(fill) + CNT_W'(cmd.n);
		act_sum    = speech_q + CNT_W'(cmd.n);
		part       = (act_sum >= {1'b0, cfg.max_speech});
		after_part = part ? '0 : act_sum;
		sil_sum    = silence_q + CNT_W'(cmd.n);
		sil_done   = (sil_sum >= {1'b0, cfg.min_sil});
		keep_final = (after_part >= {1'b0, cfg.min_speech}) && (after_part != '0);
	end

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (cmd_pop && !cmd.zero) begin
			unique case (mode_q) inside
				MODE_IDLE: begin
					if (cmd.ge_start) mode_d = MODE_SPEECH;
				end
				MODE_SPEECH, MODE_SILENCE: begin
					if (cmd.lt_sil) mode_d = sil_done ? MODE_IDLE : MODE_SILENCE;
					else            mode_d = MODE_SPEECH;
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	// Counters and the result item.
	always_comb begin
		speech_d  = speech_q;
		silence_d = silence_q;
		preroll_d = preroll_q;
		start_d   = start_q;
		res_d     = '0;
		res_d.segment_start_ms = start_q;
		res_d.mode             = mode_d;
		res_d.end_kind         = END_NONE;
		if (cmd_pop && !cmd.zero) begin
			preroll_d = fill;
			if (mode_q == MODE_IDLE) begin
				if (cmd.ge_start) begin
					speech_d  = start_cnt;
					silence_d = '0;
					start_d   = cmd.tms;
					res_d.speech_started   = 1'b1;
					res_d.barge_in         = cmd.asst;
					res_d.segment_start_ms = cmd.tms;
				end
			end else begin
				speech_d = after_part;
				res_d.partial_emitted = part;
				res_d.partial_length  = part ? act_sum : '0;
				if (cmd.lt_sil) begin
					silence_d = sil_sum;
					if (sil_done) begin
						res_d.end_kind     = keep_final ? END_FINAL : END_DROPPED;
						res_d.final_length = keep_final ? after_part : '0;
						speech_d  = '0;
						silence_d = '0;
						preroll_d = '0;
						start_d   = '0;
					end
				end else begin
					silence_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			speech_q    <= '0;
			silence_q   <= '0;
			preroll_q   <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			speech_q  <= speech_d;
			silence_q <= silence_d;
			preroll_q <= preroll_d;
			start_q   <= start_d;
			if (cmd_pop)        out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) out_q <= res_d;
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> (speech_q == '0 && silence_q == '0 && start_q == '0))
		else $error("idle with segment state left over");

	a_silence_mode: assert property (@(posedge clk) disable iff (!arst_n)
		silence_q != '0 |-> mode_q == MODE_SILENCE)
		else $error("silence count outside silence mode");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && res_d.end_kind != END_NONE |=> mode_q == MODE_IDLE)
		else $error("segment ended but mode not idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_ready |-> !cmd_pop)
		else $error("pending result overwritten");

endmodule

>>> src/vad_hysteresis_segmenter_core.sv
// Voice-activity segmenter with hysteresis. Each request on the slave stream
// is one audio frame; each frame produces exactly one result request on the
// master stream, in order. A probability at or above start_threshold opens a
// segment (pre-roll plus frame counted, barge-in flagged when the assistant is
// speaking); a partial segment is reported whenever the running count reaches
// max_speech_samples; enough continuous silence below start_threshold minus
// hysteresis_offset closes the segment as final or dropped. Zero-length frames
// change nothing. Throughput is one frame per clock sustained while the
// master stream is ready. The front end classifies the frame in the accept
// cycle and writes it into a QDEPTH-entry queue (4 by default); the back end
// pops it, updates segment state (which sets that rate) and loads the result
// register. The user must write the configuration registers through cfg_we/
// cfg_addr/cfg_wdata only while no frame is in flight; the block does not
// enforce this. Indexes 6 and 7 are ignored.
module vad_hysteresis_segmenter_core import vhs_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF,
	parameter int unsigned QDEPTH    = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// speech_prob[15:0], frame_samples[28:16], frame_time_ms[60:29],
	// assistant_speaking[61], zero fill[63:62]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// speech_started[0], barge_in[1], partial_emitted[2], partial_length[23:3],
	// end_kind[25:24], final_length[46:26], segment_start_ms[78:47],
	// mode[80:79], zero fill[87:81]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	cfg_t       cfg_q;
	frame_cmd_t front_cmd, queue_cmd;
	logic       q_full, q_not_empty, q_pop, push;
	result_t    res;

	// Configuration registers: write-only, take the low bits of the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_thr  <= RST_START_THR;
			cfg_q.hyst_off   <= RST_HYST_OFF;
			cfg_q.min_sil    <= RST_MIN_SIL;
			cfg_q.pad        <= RST_PAD;
			cfg_q.min_speech <= RST_MIN_SPEECH;
			cfg_q.max_speech <= RST_MAX_SPEECH;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_START_THR:  cfg_q.start_thr  <= cfg_wdata[PROB_W-1:0];
				REG_HYST_OFF:   cfg_q.hyst_off   <= cfg_wdata[PROB_W-1:0];
				REG_MIN_SIL:    cfg_q.min_sil    <= cfg_wdata[LIM_W-1:0];
				REG_PAD:        cfg_q.pad        <= cfg_wdata[PAD_W-1:0];
				REG_MIN_SPEECH: cfg_q.min_speech <= cfg_wdata[LIM_W-1:0];
				REG_MAX_SPEECH: cfg_q.max_speech <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept whenever the queue has room, independent of the output side.
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	vhs_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.speech_prob        (s_axis_tdata[15:0]),
		.frame_samples      (s_axis_tdata[28:16]),
		.frame_time_ms      (s_axis_tdata[60:29]),
		.assistant_speaking (s_axis_tdata[61]),
		.cfg                (cfg_q),
		.cmd                (front_cmd)
	);

	vhs_fifo #(
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (queue_cmd),
		.not_empty (q_not_empty)
	);

	vhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_not_empty),
		.cmd       (queue_cmd),
		.cmd_pop   (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result fields, speech_started in the lowest bits.
	assign m_axis_tdata = {
		7'b0,
		res.mode,
		res.segment_start_ms,
		res.final_length,
		res.end_kind,
		res.partial_length,
		res.partial_emitted,
		res.barge_in,
		res.speech_started
	};

endmodule
